### src/plfs_pkg.sv
// Shared widths, register codes and configuration type for the line-follow PID steering block.
package plfs_pkg;

    localparam int SENSOR_W   = 7;
    localparam int GAIN_W     = 24;
    localparam int SPEED_W    = 11;
    localparam int OFFS_W     = 8;
    localparam int ERR_W      = 8;
    localparam int DERIV_W    = 9;
    localparam int DRIVE_W    = 16;
    localparam int STEER_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TARGET_LEVEL = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_CRUISE_SPEED = 3'd4,
        CFG_RIGHT_OFFSET = 3'd5,
        CFG_LEFT_OFFSET  = 3'd6
    } t_cfg_addr;

    typedef struct packed {
        logic [SENSOR_W-1:0] target_level;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [SPEED_W-1:0]  cruise_speed;
        logic [OFFS_W-1:0]   right_offset;
        logic [OFFS_W-1:0]   left_offset;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target_level: 7'd45,
        gain_p:       24'd65536,
        gain_i:       24'd66,
        gain_d:       24'd66,
        cruise_speed: 11'd100,
        right_offset: 8'd55,
        left_offset:  8'd45
    };

endpackage

### src/plfs_if.sv
// Channel interfaces: sensor input, steering result and configuration write.
interface plfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [plfs_pkg::SENSOR_W-1:0] sensor_level;

    modport source (output valid, sensor_level, input ready);
    modport sink   (input valid, sensor_level, output ready);
endinterface

interface plfs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [plfs_pkg::DRIVE_W-1:0] drive_a;
    logic signed [plfs_pkg::DRIVE_W-1:0] drive_d;
    logic signed [plfs_pkg::STEER_W-1:0] steer_value;

    modport source (output valid, drive_a, drive_d, steer_value, input ready);
    modport sink   (input valid, drive_a, drive_d, steer_value, output ready);
endinterface

interface plfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [plfs_pkg::CFG_ADDR_W-1:0] addr;
    logic [plfs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### src/plfs_err.sv
// Error stage: error, saturating integral and derivative; holds the loop state.
module plfs_err #(
    parameter int INTEGRAL_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [plfs_pkg::SENSOR_W-1:0]        i_sample,
    input  logic [plfs_pkg::SENSOR_W-1:0]        i_target,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [plfs_pkg::ERR_W-1:0]    o_err,
    output logic signed [INTEGRAL_WIDTH-1:0]     o_integ,
    output logic signed [plfs_pkg::DERIV_W-1:0]  o_deriv
);
    import plfs_pkg::*;

    localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    logic                             r_valid;
    logic signed [ERR_W-1:0]          r_err;    // doubles as previous error
    logic signed [INTEGRAL_WIDTH-1:0] r_integ;  // the running integral itself
    logic signed [DERIV_W-1:0]        r_deriv;

    logic signed [ERR_W-1:0]          n_err;
    logic signed [INTEGRAL_WIDTH:0]   n_sum;
    logic signed [INTEGRAL_WIDTH-1:0] n_integ;
    logic signed [DERIV_W-1:0]        n_deriv;
    logic                             load;

    // A new item loads only when the held one moves on, so the single
    // register set is both stage data and loop state.
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_err   = $signed(ERR_W'(i_target)) - $signed(ERR_W'(i_sample));
        n_sum   = (INTEGRAL_WIDTH+1)'(r_integ) + (INTEGRAL_WIDTH+1)'(n_err);
        if (n_sum[INTEGRAL_WIDTH] != n_sum[INTEGRAL_WIDTH-1]) begin
            n_integ = n_sum[INTEGRAL_WIDTH] ? IMIN : IMAX;
        end else begin
            n_integ = n_sum[INTEGRAL_WIDTH-1:0];
        end
        n_deriv = DERIV_W'(n_err) - DERIV_W'(r_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= '0;
            r_integ <= INTEGRAL_WIDTH'(1);
            r_deriv <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_err   <= n_err;
                r_integ <= n_integ;
                r_deriv <= n_deriv;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_integ = r_integ;
    assign o_deriv = r_deriv;

endmodule

### src/plfs_mac.sv
// Gain stage: three registered products, then their sum saturated to 32 bits.
module plfs_mac #(
    parameter int INTEGRAL_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [plfs_pkg::ERR_W-1:0]    i_err,
    input  logic signed [INTEGRAL_WIDTH-1:0]     i_integ,
    input  logic signed [plfs_pkg::DERIV_W-1:0]  i_deriv,
    input  plfs_pkg::t_cfg                       i_cfg,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [plfs_pkg::STEER_W-1:0]  o_steer
);
    import plfs_pkg::*;

    localparam int PW_P  = GAIN_W + 1 + ERR_W;
    localparam int PW_I  = GAIN_W + 1 + INTEGRAL_WIDTH;
    localparam int PW_D  = GAIN_W + 1 + DERIV_W;
    localparam int PW_M  = (PW_I > PW_D) ? PW_I : PW_D;
    localparam int SUM_W = PW_M + 2;

    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'({1'b0, {(STEER_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    logic                      r_v1;
    logic                      r_v2;
    logic signed [PW_P-1:0]    r_prod_p;
    logic signed [PW_I-1:0]    r_prod_i;
    logic signed [PW_D-1:0]    r_prod_d;
    logic signed [STEER_W-1:0] r_steer;

    logic signed [PW_P-1:0]    n_prod_p;
    logic signed [PW_I-1:0]    n_prod_i;
    logic signed [PW_D-1:0]    n_prod_d;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [STEER_W-1:0] n_steer;
    logic                      s2_ready;

    assign s2_ready = !r_v2 || i_ready;
    assign o_ready  = !r_v1 || s2_ready;

    // gains are unsigned: a zero sign bit turns them into signed operands
    assign n_prod_p = $signed(PW_P'({1'b0, i_cfg.gain_p})) * PW_P'(i_err);
    assign n_prod_i = $signed(PW_I'({1'b0, i_cfg.gain_i})) * PW_I'(i_integ);
    assign n_prod_d = $signed(PW_D'({1'b0, i_cfg.gain_d})) * PW_D'(i_deriv);

    always_comb begin
        n_sum = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
        if (n_sum > SMAX) begin
            n_steer = SMAX[STEER_W-1:0];
        end else if (n_sum < SMIN) begin
            n_steer = SMIN[STEER_W-1:0];
        end else begin
            n_steer = n_sum[STEER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (r_v1 && s2_ready) begin
            r_steer <= n_steer;
        end
    end

    assign o_valid = r_v2;
    assign o_steer = r_steer;

endmodule

### src/plfs_drive.sv
// Steering stage: wheel speeds from the steer value, drives to the output register.
module plfs_drive #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [plfs_pkg::STEER_W-1:0]  i_steer,
    input  plfs_pkg::t_cfg                       i_cfg,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [plfs_pkg::DRIVE_W-1:0]  o_drive_a,
    output logic signed [plfs_pkg::DRIVE_W-1:0]  o_drive_d,
    output logic signed [plfs_pkg::STEER_W-1:0]  o_steer
);
    import plfs_pkg::*;

    localparam int DW0 = ((SPEED_W + FRAC_BITS + 1) > STEER_W) ?
                         (SPEED_W + FRAC_BITS + 1) : STEER_W;
    localparam int DW  = DW0 + 2;

    localparam logic signed [DW-1:0] BIAS = DW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [DW-1:0] DMAX = DW'({1'b0, {(DRIVE_W-1){1'b1}}});
    localparam logic signed [DW-1:0] DMIN = ~DMAX;

    // negated speed in fixed point -> whole drive, truncated toward zero, clamped
    function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] adj;
        logic signed [DW-1:0] q;
        adj = v[DW-1] ? (v + BIAS) : v;
        q   = adj >>> FRAC_BITS;
        if (q > DMAX) begin
            return DMAX[DRIVE_W-1:0];
        end else if (q < DMIN) begin
            return DMIN[DRIVE_W-1:0];
        end
        return q[DRIVE_W-1:0];
    endfunction

    logic                      r_valid;
    logic signed [DRIVE_W-1:0] r_drive_a;
    logic signed [DRIVE_W-1:0] r_drive_d;
    logic signed [STEER_W-1:0] r_steer;

    logic signed [DW-1:0] base_q;
    logic signed [DW-1:0] roff_q;
    logic signed [DW-1:0] loff_q;
    logic signed [DW-1:0] steer_x;
    logic signed [DW-1:0] n_neg_a;
    logic signed [DW-1:0] n_neg_d;

    assign o_ready = !r_valid || i_ready;

    assign base_q  = $signed(DW'({i_cfg.cruise_speed, {FRAC_BITS{1'b0}}}));
    assign roff_q  = $signed(DW'({i_cfg.right_offset, {FRAC_BITS{1'b0}}}));
    assign loff_q  = $signed(DW'({i_cfg.left_offset, {FRAC_BITS{1'b0}}}));
    assign steer_x = DW'(i_steer);

    always_comb begin
        n_neg_a = -base_q;
        n_neg_d = -base_q;
        if (i_steer != '0) begin
            if (!i_steer[STEER_W-1]) begin
                n_neg_a = steer_x + roff_q - base_q;
            end else begin
                n_neg_d = -steer_x + loff_q - base_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_drive_a <= to_drive(n_neg_a);
            r_drive_d <= to_drive(n_neg_d);
            r_steer   <= i_steer;
        end
    end

    assign o_valid   = r_valid;
    assign o_drive_a = r_drive_a;
    assign o_drive_d = r_drive_d;
    assign o_steer   = r_steer;

endmodule

### src/pid_line_follow_steer.sv
// Top level of the PID steering block for a two-wheel line follower.
// Each light sample gives one result: two motor drives and the PID steer value.
// A sample can be taken every clock cycle while the error stage is ready; a result
// is presented once its sample has passed the error, product, sum and output
// registers in that order, and a stalled output backs up only as far as the
// first free register. The integral and previous error live in the error
// register, which updates once per transferred sample. Configuration writes are
// taken every cycle and must only be made while no sample is in flight.
module pid_line_follow_steer #(
    parameter int FRAC_BITS      = 16,
    parameter int INTEGRAL_WIDTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plfs_in_if.sink    i_in,
    plfs_out_if.source o_out,
    plfs_cfg_if.sink   i_cfg
);
    import plfs_pkg::*;

    t_cfg r_cfg;

    logic                      err_valid;
    logic                      err_ready;
    logic signed [ERR_W-1:0]   err_err;
    logic signed [INTEGRAL_WIDTH-1:0] err_integ;
    logic signed [DERIV_W-1:0] err_deriv;
    logic                      mac_valid;
    logic                      mac_ready;
    logic signed [STEER_W-1:0] mac_steer;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_TARGET_LEVEL: r_cfg.target_level <= i_cfg.data[SENSOR_W-1:0];
                CFG_GAIN_P:       r_cfg.gain_p       <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_I:       r_cfg.gain_i       <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_D:       r_cfg.gain_d       <= i_cfg.data[GAIN_W-1:0];
                CFG_CRUISE_SPEED: r_cfg.cruise_speed <= i_cfg.data[SPEED_W-1:0];
                CFG_RIGHT_OFFSET: r_cfg.right_offset <= i_cfg.data[OFFS_W-1:0];
                CFG_LEFT_OFFSET:  r_cfg.left_offset  <= i_cfg.data[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    plfs_err #(
        .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
    ) u_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_sample (i_in.sensor_level),
        .i_target (r_cfg.target_level),
        .o_valid  (err_valid),
        .i_ready  (err_ready),
        .o_err    (err_err),
        .o_integ  (err_integ),
        .o_deriv  (err_deriv)
    );

    plfs_mac #(
        .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (err_valid),
        .o_ready  (err_ready),
        .i_err    (err_err),
        .i_integ  (err_integ),
        .i_deriv  (err_deriv),
        .i_cfg    (r_cfg),
        .o_valid  (mac_valid),
        .i_ready  (mac_ready),
        .o_steer  (mac_steer)
    );

    plfs_drive #(
        .FRAC_BITS(FRAC_BITS)
    ) u_drive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mac_valid),
        .o_ready   (mac_ready),
        .i_steer   (mac_steer),
        .i_cfg     (r_cfg),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_drive_a (o_out.drive_a),
        .o_drive_d (o_out.drive_d),
        .o_steer   (o_out.steer_value)
    );

`ifndef ASSERT_OFF
    // integral restarts at one
    a_integ_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> err_integ == INTEGRAL_WIDTH'(1))
        else $error("integral not one after reset");

    // loop state moves only on a sample transfer
    a_integ_hold: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && !$past(i_in.valid && i_in.ready))
            |-> err_integ == $past(err_integ))
        else $error("integral changed without a sample");

    // zero steer drives both wheels alike
    a_zero_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.steer_value == '0) |-> o_out.drive_a == o_out.drive_d)
        else $error("zero steer gave unequal drives");
`endif

endmodule
